// File: hdl/srgbxy_pkg.sv
// srgbxy_pkg: shared constants and elaboration-time table builders for the
// sRGB to CIE xy chromaticity unit. No dependencies.
`timescale 1ns / 1ps

package srgbxy_pkg;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  // matrix coefficients in millionths: rows X, Y, Z; columns red, green, blue
  localparam logic [19:0] MAT_MICRO [0:2][0:2] = '{
    '{20'd664511, 20'd154324, 20'd162028},
    '{20'd283881, 20'd668433, 20'd47685},
    '{20'd88,     20'd72310,  20'd986039}
  };

  // sRGB transfer curve for one 8-bit code, unsigned Q0.frac_bits, saturated
  function automatic logic [63:0] lin_entry(input int code, input int frac_bits);
    logic [63:0] c;
    logic [63:0] n;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] u;
    logic [63:0] y;
    logic [63:0] cand;
    logic [63:0] p2;
    logic [63:0] p4;
    logic [63:0] p5;
    logic [63:0] lin;
    logic [63:0] fmax;
    int          b;
    c    = 64'(code) & 64'hFF;
    fmax = (64'd1 << frac_bits) - 64'd1;
    if (c <= 64'd10) begin
      // linear segment near black
      lin = (((c * 64'd100) << frac_bits) + 64'd164730) / 64'd329460;
    end else begin
      // power segment: t^2.4 = t^2 * t^0.4, fifth root found bit by bit in Q30
      n = 64'd1000 * c + 64'd14025;
      t = (n << 30) / 64'd269025;
      if (t >= Q30_ONE) begin
        y = Q30_ONE;
      end else begin
        t2 = (t * t) >> 30;
        u  = 64'd0;
        for (b = 29; b >= 0; b--) begin
          cand = u | (64'd1 << b);
          p2   = (cand * cand) >> 30;
          p4   = (p2 * p2) >> 30;
          p5   = (p4 * cand) >> 30;
          if (p5 <= t2) begin
            u = cand;
          end
        end
        y = (t2 * u) >> 30;
      end
      lin = (y + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
    end
    if (lin > fmax) begin
      lin = fmax;
    end
    return lin;
  endfunction

  // one matrix coefficient, rounded to Q0.frac_bits
  function automatic logic [63:0] coef_entry(input int row, input int col,
                                             input int frac_bits);
    logic [63:0] k;
    k = 64'(MAT_MICRO[row][col]);
    return ((k << frac_bits) + 64'd500000) / 64'd1000000;
  endfunction

endpackage

// File: hdl/srgbxy_linearize.sv
// srgbxy_linearize: one registered stage that maps the three 8-bit sRGB
// codes to linear light through a constant transfer-curve table (srgbxy_pkg).
`timescale 1ns / 1ps

module srgbxy_linearize import srgbxy_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAC_BITS-1:0] lin_r,
  output logic [FRAC_BITS-1:0] lin_g,
  output logic [FRAC_BITS-1:0] lin_b
);

  logic [FRAC_BITS-1:0] rom [256];
  logic                 take;

  // transfer-curve table, built at elaboration
  for (genvar i = 0; i < 256; i++) begin : g_rom
    localparam logic [63:0] ENT = lin_entry(i, FRAC_BITS);
    assign rom[i] = ENT[FRAC_BITS-1:0];
  end

  // stage loads when empty or when its beat moves on
  assign take     = !out_valid || out_ready;
  assign in_ready = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= in_valid;
    end
  end

  // table lookups
  always_ff @(posedge clk) begin
    if (take) begin
      lin_r <= rom[red];
      lin_g <= rom[green];
      lin_b <= rom[blue];
    end
  end

endmodule

// File: hdl/srgbxy_matrix.sv
// srgbxy_matrix: three-stage 3x3 matrix (products, row sums, total) giving
// X, Y and X+Y+Z in Q2.2F plus a black flag. Coefficients from srgbxy_pkg.
`timescale 1ns / 1ps

module srgbxy_matrix import srgbxy_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [FRAC_BITS-1:0]     lin_r,
  input  logic [FRAC_BITS-1:0]     lin_g,
  input  logic [FRAC_BITS-1:0]     lin_b,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2*FRAC_BITS+1:0]   tri_x,
  output logic [2*FRAC_BITS+1:0]   tri_y,
  output logic [2*FRAC_BITS+1:0]   tri_sum,
  output logic                     black
);

  localparam int PW = 2 * FRAC_BITS;
  localparam int TW = 2 * FRAC_BITS + 2;

  logic [FRAC_BITS-1:0] coef  [3][3];
  logic [FRAC_BITS-1:0] lin_a [3];
  logic [PW-1:0]        prod  [3][3];
  logic [TW-1:0]        row_s [3];
  logic                 v1;
  logic                 v2;
  logic                 take1;
  logic                 take2;
  logic                 take3;

  // coefficient constants
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam logic [63:0] CE = coef_entry(r, c, FRAC_BITS);
      assign coef[r][c] = CE[FRAC_BITS-1:0];
    end
  end

  assign lin_a[0] = lin_r;
  assign lin_a[1] = lin_g;
  assign lin_a[2] = lin_b;

  // per-stage load enables, back to front
  assign take3    = !out_valid || out_ready;
  assign take2    = !v2 || take3;
  assign take1    = !v1 || take2;
  assign in_ready = take1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take1) begin
        v1 <= in_valid;
      end
      if (take2) begin
        v2 <= v1;
      end
      if (take3) begin
        out_valid <= v2;
      end
    end
  end

  // stage 1: nine products
  always_ff @(posedge clk) begin
    if (take1) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= PW'(lin_a[c]) * PW'(coef[r][c]);
        end
      end
    end
  end

  // stage 2: row sums
  always_ff @(posedge clk) begin
    if (take2) begin
      for (int r = 0; r < 3; r++) begin
        row_s[r] <= TW'(prod[r][0]) + TW'(prod[r][1]) + TW'(prod[r][2]);
      end
    end
  end

  // stage 3: total and black detect
  always_ff @(posedge clk) begin
    if (take3) begin
      tri_x   <= row_s[0];
      tri_y   <= row_s[1];
      tri_sum <= row_s[0] + row_s[1] + row_s[2];
      black   <= ((row_s[0] | row_s[1] | row_s[2]) == '0);
    end
  end

endmodule

// File: hdl/srgbxy_divider.sv
// srgbxy_divider: pipelined restoring divider, one quotient bit per stage,
// forming X/S and Y/S in Q0.F with saturation and black override. No package use.
`timescale 1ns / 1ps

module srgbxy_divider #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2*FRAC_BITS+1:0] num_x,
  input  logic [2*FRAC_BITS+1:0] num_y,
  input  logic [2*FRAC_BITS+1:0] den,
  input  logic                   black,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [FRAC_BITS-1:0]   chroma_x,
  output logic [FRAC_BITS-1:0]   chroma_y,
  output logic                   is_black
);

  localparam int TW = 2 * FRAC_BITS + 2;
  localparam int RW = TW + 1;
  localparam int NS = FRAC_BITS + 1;

  logic          dv   [NS];
  logic          db   [NS];
  logic [TW-1:0] dd   [NS];
  logic [RW-1:0] rx   [NS];
  logic [RW-1:0] ry   [NS];
  logic [FRAC_BITS:0] qx [NS];
  logic [FRAC_BITS:0] qy [NS];
  logic          take [NS+1];

  // load enables, back to front; the last one feeds the output register
  assign take[NS] = !out_valid || out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_take
    assign take[k] = !dv[k] || take[k+1];
  end
  assign in_ready = take[0];

  // one compare-subtract step per stage for both ratios
  for (genvar k = 0; k < NS; k++) begin : g_step
    logic               src_v;
    logic               src_b;
    logic [TW-1:0]      src_d;
    logic [RW-1:0]      rin_x;
    logic [RW-1:0]      rin_y;
    logic [FRAC_BITS:0] src_qx;
    logic [FRAC_BITS:0] src_qy;
    logic [RW-1:0]      dext;
    logic               gex;
    logic               gey;

    if (k == 0) begin : g_first
      assign src_v  = in_valid;
      assign src_b  = black;
      assign src_d  = den;
      assign rin_x  = {1'b0, num_x};
      assign rin_y  = {1'b0, num_y};
      assign src_qx = '0;
      assign src_qy = '0;
    end else begin : g_next
      assign src_v  = dv[k-1];
      assign src_b  = db[k-1];
      assign src_d  = dd[k-1];
      assign rin_x  = {rx[k-1][RW-2:0], 1'b0};
      assign rin_y  = {ry[k-1][RW-2:0], 1'b0};
      assign src_qx = qx[k-1];
      assign src_qy = qy[k-1];
    end

    assign dext = {1'b0, src_d};
    assign gex  = (rin_x >= dext);
    assign gey  = (rin_y >= dext);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (take[k]) begin
        dv[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (take[k]) begin
        db[k] <= src_b;
        dd[k] <= src_d;
        rx[k] <= gex ? (rin_x - dext) : rin_x;
        ry[k] <= gey ? (rin_y - dext) : rin_y;
        qx[k] <= {src_qx[FRAC_BITS-1:0], gex};
        qy[k] <= {src_qy[FRAC_BITS-1:0], gey};
      end
    end
  end

  // output register: saturate a ratio of one, zero out black pixels
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take[NS]) begin
      out_valid <= dv[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (take[NS]) begin
      is_black <= db[NS-1];
      if (db[NS-1]) begin
        chroma_x <= '0;
        chroma_y <= '0;
      end else begin
        chroma_x <= qx[NS-1][FRAC_BITS] ? '1 : qx[NS-1][FRAC_BITS-1:0];
        chroma_y <= qy[NS-1][FRAC_BITS] ? '1 : qy[NS-1][FRAC_BITS-1:0];
      end
    end
  end

endmodule

// File: hdl/srgb_to_xy_chromaticity_unit.sv
// A pixel passes one table stage, three matrix stages, FRAC_BITS + 1 divider steps
// and one output register. Throughput: one pixel per cycle while out_ready is high;
// the divider gives one quotient bit per stage.
// Each stage holds its beat while stalled and fills bubbles, so input is taken
// whenever some stage downstream is free. Reset clears only the valid bits.
// Depends on srgbxy_linearize, srgbxy_matrix, srgbxy_divider.
`timescale 1ns / 1ps

module srgb_to_xy_chromaticity_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAC_BITS-1:0] chroma_x,
  output logic [FRAC_BITS-1:0] chroma_y,
  output logic                 is_black
);

  localparam int TW = 2 * FRAC_BITS + 2;

  logic                 lin_valid;
  logic                 lin_ready;
  logic [FRAC_BITS-1:0] lin_r;
  logic [FRAC_BITS-1:0] lin_g;
  logic [FRAC_BITS-1:0] lin_b;
  logic                 mat_valid;
  logic                 mat_ready;
  logic [TW-1:0]        tri_x;
  logic [TW-1:0]        tri_y;
  logic [TW-1:0]        tri_sum;
  logic                 black;

  // sRGB decode to linear light
  srgbxy_linearize #(
    .FRAC_BITS (FRAC_BITS)
  ) u_linearize (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (lin_valid),
    .out_ready (lin_ready),
    .lin_r     (lin_r),
    .lin_g     (lin_g),
    .lin_b     (lin_b)
  );

  // linear RGB to XYZ
  srgbxy_matrix #(
    .FRAC_BITS (FRAC_BITS)
  ) u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lin_valid),
    .in_ready  (lin_ready),
    .lin_r     (lin_r),
    .lin_g     (lin_g),
    .lin_b     (lin_b),
    .out_valid (mat_valid),
    .out_ready (mat_ready),
    .tri_x     (tri_x),
    .tri_y     (tri_y),
    .tri_sum   (tri_sum),
    .black     (black)
  );

  // chromaticity ratios
  srgbxy_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mat_valid),
    .in_ready  (mat_ready),
    .num_x     (tri_x),
    .num_y     (tri_y),
    .den       (tri_sum),
    .black     (black),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .chroma_x  (chroma_x),
    .chroma_y  (chroma_y),
    .is_black  (is_black)
  );

endmodule

// File: bench/srgbxy_chroma_checker.sv
// srgbxy_chroma_checker: watches the pixel and chromaticity channels of the
// sRGB to xy unit, predicts each result and compares it. Standalone, no package.
`timescale 1ns / 1ps

module srgbxy_chroma_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [FRAC_BITS-1:0] chroma_x,
  input  logic [FRAC_BITS-1:0] chroma_y,
  input  logic                 is_black,
  output int                   errors,
  output int                   pending
);

  localparam logic [63:0] ONE_Q30  = 64'd1 << 30;
  localparam logic [63:0] FRAC_TOP = (64'd1 << FRAC_BITS) - 64'd1;

  typedef struct packed {
    logic [FRAC_BITS-1:0] x;
    logic [FRAC_BITS-1:0] y;
    logic                 black;
  } chroma_t;

  logic [63:0] gamma_lut [0:255];
  logic [63:0] xyz_coef  [0:8];
  chroma_t     chroma_due [$];
  int          mismatches = 0;
  int          due_count  = 0;

  assign errors  = mismatches;
  assign pending = due_count;

  // srgb decode of one code: linear toe, else t^2 * t^0.4 in q30
  function automatic logic [63:0] decode_gamma(input int code);
    logic [63:0] c;
    logic [63:0] num;
    logic [63:0] t;
    logic [63:0] t_sq;
    logic [63:0] root;
    logic [63:0] trial;
    logic [63:0] sq;
    logic [63:0] quad;
    logic [63:0] fifth;
    logic [63:0] pw;
    logic [63:0] lin;
    int          b;
    c = 64'(code) & 64'hFF;
    if (c <= 64'd10) begin
      lin = (((c * 64'd100) << FRAC_BITS) + 64'd164730) / 64'd329460;
    end else begin
      num = 64'd1000 * c + 64'd14025;
      t   = (num << 30) / 64'd269025;
      if (t >= ONE_Q30) begin
        pw = ONE_Q30;
      end else begin
        t_sq = (t * t) >> 30;
        root = 64'd0;
        // fifth root of t^2, one bit at a time from the top
        for (b = 29; b >= 0; b--) begin
          trial = root | (64'd1 << b);
          sq    = (trial * trial) >> 30;
          quad  = (sq * sq) >> 30;
          fifth = (quad * trial) >> 30;
          if (fifth <= t_sq) begin
            root = trial;
          end
        end
        pw = (t_sq * root) >> 30;
      end
      lin = (pw + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    end
    if (lin > FRAC_TOP) begin
      lin = FRAC_TOP;
    end
    return lin;
  endfunction

  // coefficient given in millionths, rounded to q0.frac
  function automatic logic [63:0] micro_to_coef(input logic [63:0] micro);
    return ((micro << FRAC_BITS) + 64'd500000) / 64'd1000000;
  endfunction

  // floor(part * 2^frac / whole), clipped to the field
  function automatic logic [FRAC_BITS-1:0] share_of(input logic [63:0] part,
                                                     input logic [63:0] whole);
    logic [63:0] q;
    q = (part << FRAC_BITS) / whole;
    if (q > FRAC_TOP) begin
      q = FRAC_TOP;
    end
    return q[FRAC_BITS-1:0];
  endfunction

  function automatic chroma_t predict_chroma(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
    logic [63:0] lr;
    logic [63:0] lg;
    logic [63:0] lb;
    logic [63:0] cx;
    logic [63:0] cy;
    logic [63:0] cz;
    logic [63:0] total;
    chroma_t     res;
    lr = gamma_lut[r];
    lg = gamma_lut[g];
    lb = gamma_lut[b];
    cx = lr * xyz_coef[0] + lg * xyz_coef[1] + lb * xyz_coef[2];
    cy = lr * xyz_coef[3] + lg * xyz_coef[4] + lb * xyz_coef[5];
    cz = lr * xyz_coef[6] + lg * xyz_coef[7] + lb * xyz_coef[8];
    total = cx + cy + cz;
    if (total == 64'd0) begin
      res.x     = '0;
      res.y     = '0;
      res.black = 1'b1;
    end else begin
      res.x     = share_of(cx, total);
      res.y     = share_of(cy, total);
      res.black = 1'b0;
    end
    return res;
  endfunction

  task automatic report(input string field, input logic [63:0] want,
                        input logic [63:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  // tables filled once at start
  initial begin : build_tables
    int i;
    for (i = 0; i < 256; i++) begin
      gamma_lut[i] = decode_gamma(i);
    end
    xyz_coef[0] = micro_to_coef(64'd664511);
    xyz_coef[1] = micro_to_coef(64'd154324);
    xyz_coef[2] = micro_to_coef(64'd162028);
    xyz_coef[3] = micro_to_coef(64'd283881);
    xyz_coef[4] = micro_to_coef(64'd668433);
    xyz_coef[5] = micro_to_coef(64'd47685);
    xyz_coef[6] = micro_to_coef(64'd88);
    xyz_coef[7] = micro_to_coef(64'd72310);
    xyz_coef[8] = micro_to_coef(64'd986039);
  end

  // predict on each pixel beat, compare on each result beat
  always @(posedge clk) begin : score
    chroma_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        chroma_due.push_back(predict_chroma(red, green, blue));
      end
      if (out_valid && out_ready) begin
        if (chroma_due.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing outstanding, expected no beat, got x %0d y %0d black %0d",
                   $time, chroma_x, chroma_y, is_black);
        end else begin
          want = chroma_due.pop_front();
          if (chroma_x !== want.x) begin
            report("chroma_x", 64'(want.x), 64'(chroma_x));
          end
          if (chroma_y !== want.y) begin
            report("chroma_y", 64'(want.y), 64'(chroma_y));
          end
          if (is_black !== want.black) begin
            report("is_black", 64'(want.black), 64'(is_black));
          end
        end
      end
    end
    due_count = chroma_due.size();
  end

endmodule

// File: bench/tb_top.sv
// tb_top: drives pixels into srgb_to_xy_chromaticity_unit and gives the verdict.
// Depends on srgb_to_xy_chromaticity_unit and srgbxy_chroma_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int FRAC_BITS    = 16;
  localparam int LATENCY      = FRAC_BITS + 6;
  localparam int RANDOM_BEATS = 1300;
  localparam int HOLD_CYCLES  = 150;
  localparam int CYCLE_LIMIT  = 500000;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           red;
  logic [7:0]           green;
  logic [7:0]           blue;
  logic                 out_valid;
  logic                 out_ready;
  logic [FRAC_BITS-1:0] chroma_x;
  logic [FRAC_BITS-1:0] chroma_y;
  logic                 is_black;
  int                   errors;
  int                   pending;
  int                   steady_left = 0;

  srgb_to_xy_chromaticity_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .chroma_x (chroma_x),
    .chroma_y (chroma_y),
    .is_black (is_black)
  );

  srgbxy_chroma_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) i_checker (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .chroma_x (chroma_x),
    .chroma_y (chroma_y),
    .is_black (is_black),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // one pixel beat, with an optional gap ahead of it
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    if (steady_left > 0) begin
      gap = 0;
      steady_left--;
    end else begin
      gap = idle_len();
    end
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    red      <= r;
    green    <= g;
    blue     <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // channel value for one random pixel, by flavor
  function automatic logic [7:0] pick_level(input int flavor);
    case (flavor)
      6: begin
        return 8'($urandom_range(0, 12));
      end
      7: begin
        return 8'($urandom_range(8, 14));
      end
      8: begin
        case ($urandom_range(0, 3))
          0: return 8'd0;
          1: return 8'd1;
          2: return 8'd254;
          default: return 8'd255;
        endcase
      end
      default: begin
        return 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  // pixel source
  initial begin : pixel_source
    int          n;
    int          flavor;
    logic [7:0]  lvl;
    rst      = 1'b1;
    in_valid = 1'b0;
    red      = 8'd0;
    green    = 8'd0;
    blue     = 8'd0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: black, white, primaries, toe and knee of the curve
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd10, 8'd10, 8'd10);
    send_pixel(8'd11, 8'd11, 8'd11);
    send_pixel(8'd10, 8'd11, 8'd12);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd254, 8'd254, 8'd254);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'h55, 8'hAA, 8'h55);

    // random pixels in mixed flavors
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if ($urandom_range(0, 49) == 0) begin
        steady_left = $urandom_range(20, 60);
      end
      flavor = $urandom_range(0, 9);
      if (flavor == 9) begin
        lvl = pick_level(0);
        send_pixel(lvl, lvl, lvl);
      end else begin
        send_pixel(pick_level(flavor), pick_level(flavor), pick_level(flavor));
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then let the pipeline settle
    while (pending != 0) @(negedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // result sink: random ready runs and stalls, plus long hold-offs
  initial begin : result_sink
    int tick;
    int ready_run;
    int stall_run;
    tick      = 0;
    ready_run = 0;
    stall_run = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (tick == 700 || tick == 2200) begin
        stall_run = HOLD_CYCLES;
      end
      if (stall_run > 0) begin
        out_ready <= 1'b0;
        stall_run--;
      end else if (ready_run > 0) begin
        out_ready <= 1'b1;
        ready_run--;
      end else begin
        out_ready <= 1'b1;
        ready_run = $urandom_range(0, 15);
        stall_run = ($urandom_range(0, 3) == 0) ? 0 : idle_len();
      end
    end
  end

  // watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule
